// ----- rtl/core/pmct_pkg.sv -----
// Package for the PS/2 mouse packet click tracker.
// Types, constants and the cursor clamp used by all pmct modules. No dependencies.
`timescale 1ns / 1ps

package pmct_pkg;

  localparam int CURSOR_SIZE = 16;
  localparam int NUM_BUTTONS = 3;
  localparam int BTN_W       = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam int SYNC_BIT    = 3;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;

  localparam logic [11:0] SCREEN_W_RST = 12'd800;
  localparam logic [11:0] SCREEN_H_RST = 12'd600;
  localparam logic [6:0]  CLICK_LIM_RST = 7'd50;
  localparam logic [6:0]  HOLD_CAP_RST  = 7'd100;
  localparam logic [11:0] POS_X_RST    = 12'd400;
  localparam logic [11:0] POS_Y_RST    = 12'd300;
  localparam logic [7:0]  CLICK_MAX    = 8'd255;

  typedef enum logic [1:0] {
    CMD_BYTE        = 2'd0,
    CMD_ACK_PRESS   = 2'd1,
    CMD_ACK_RELEASE = 2'd2,
    CMD_ACK_CLICK   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SCREEN_W  = 2'd0,
    CFG_SCREEN_H  = 2'd1,
    CFG_CLICK_LIM = 2'd2,
    CFG_HOLD_CAP  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FR_SYNC = 3'b001,
    FR_DX   = 3'b010,
    FR_DY   = 3'b100
  } frame_state_e;

  typedef struct packed {
    logic [11:0] screen_w;
    logic [11:0] screen_h;
    logic [6:0]  click_lim;
    logic [6:0]  hold_cap;
  } cfg_t;

  typedef struct packed {
    cmd_e             cmd;
    logic             is_pkt;
    logic [BTN_W-1:0] buttons;
    logic [7:0]       dx;
    logic [7:0]       dy;
    logic [BTN_W-1:0] mask;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic             packet_done;
    logic             report_event;
    logic [BTN_W-1:0] button_state;
    logic [7:0]       move_x;
    logic [7:0]       move_y;
    logic [11:0]      cursor_x;
    logic [11:0]      cursor_y;
    logic             ack_found;
    logic [BTN_W-1:0] press_pending;
    logic [BTN_W-1:0] release_pending;
    logic [BTN_W-1:0] click_pending;
  } res_t;

  function automatic logic [11:0] clamp_axis(input logic [11:0] pos,
                                             input logic signed [8:0] delta,
                                             input logic [11:0] screen);
    logic [11:0]        lim;
    logic signed [13:0] p;
    logic [11:0]        r;
    lim = (screen >= 12'(CURSOR_SIZE)) ? screen - 12'(CURSOR_SIZE) : 12'd0;
    p   = $signed({2'b00, pos}) + 14'(delta);
    if (p < 14'sd0) begin
      r = 12'd0;
    end else if (p > $signed({2'b00, lim})) begin
      r = lim;
    end else begin
      r = p[11:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/pmct_in_if.sv -----
// Input channel interface: command, mouse byte and acknowledge mask.
// Depends on nothing.
`timescale 1ns / 1ps

interface pmct_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic [2:0] ack_mask;

  modport source (output valid, cmd, data_byte, ack_mask, input ready);
  modport sink   (input valid, cmd, data_byte, ack_mask, output ready);
endinterface

// ----- rtl/core/pmct_out_if.sv -----
// Result channel interface: packet, cursor and pending event report.
// Depends on nothing.
`timescale 1ns / 1ps

interface pmct_out_if;
  logic        valid;
  logic        ready;
  logic        packet_done;
  logic        report_event;
  logic [2:0]  button_state;
  logic [7:0]  move_x;
  logic [7:0]  move_y;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;
  logic        ack_found;
  logic [2:0]  press_pending;
  logic [2:0]  release_pending;
  logic [2:0]  click_pending;

  modport source (output valid, packet_done, report_event, button_state, move_x, move_y,
                  cursor_x, cursor_y, ack_found, press_pending, release_pending,
                  click_pending, input ready);
  modport sink   (input valid, packet_done, report_event, button_state, move_x, move_y,
                  cursor_x, cursor_y, ack_found, press_pending, release_pending,
                  click_pending, output ready);
endinterface

// ----- rtl/core/pmct_front.sv -----
// Front end: accepts transactions, frames mouse bytes into packets, pushes ops.
// Depends on pmct_pkg and pmct_in_if.
`timescale 1ns / 1ps

module pmct_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  pmct_in_if.sink             in_i,
  input  pmct_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output pmct_pkg::op_t       op_o
);

  pmct_pkg::frame_state_e st_q, st_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  pmct_pkg::cmd_e cmd;
  logic accept;

  assign cmd       = pmct_pkg::cmd_e'(in_i.cmd);
  assign in_i.ready = !q_stat_i.full;
  assign accept    = in_i.valid && in_i.ready;
  assign push_o    = accept;

  always_comb begin
    op_o.cmd     = cmd;
    op_o.is_pkt  = (cmd == pmct_pkg::CMD_BYTE) && (st_q == pmct_pkg::FR_DY);
    op_o.buttons = first_q[pmct_pkg::BTN_W-1:0];
    op_o.dx      = second_q;
    op_o.dy      = in_i.data_byte;
    op_o.mask    = in_i.ack_mask;
  end

  always_comb begin
    st_d     = st_q;
    first_d  = first_q;
    second_d = second_q;
    if (accept && cmd == pmct_pkg::CMD_BYTE) begin
      unique case (st_q)
        pmct_pkg::FR_DX: begin
          second_d = in_i.data_byte;
          st_d     = pmct_pkg::FR_DY;
        end
        pmct_pkg::FR_DY: begin
          st_d = pmct_pkg::FR_SYNC;
        end
        default: begin
          if (in_i.data_byte[pmct_pkg::SYNC_BIT]) begin
            first_d = in_i.data_byte;
            st_d    = pmct_pkg::FR_DX;
          end else begin
            st_d = pmct_pkg::FR_SYNC;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= pmct_pkg::FR_SYNC;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    second_q <= second_d;
  end

endmodule

// ----- rtl/core/pmct_queue.sv -----
// Short op queue between the front end and the back end.
// Depends on pmct_pkg.
`timescale 1ns / 1ps

module pmct_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pmct_pkg::op_t     op_i,
  input  logic              pop_i,
  output pmct_pkg::op_t     head_o,
  output pmct_pkg::q_stat_t stat_o
);

  pmct_pkg::op_t ent_q [pmct_pkg::QDEPTH];
  logic [pmct_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [pmct_pkg::QCNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign stat_o.full  = (cnt_q == pmct_pkg::QCNT_W'(pmct_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = ent_q[rd_q];

  function automatic logic [pmct_pkg::QPTR_W-1:0] nxt(input logic [pmct_pkg::QPTR_W-1:0] p);
    return (p == pmct_pkg::QPTR_W'(pmct_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= nxt(wr_q);
      if (do_pop)  rd_q <= nxt(rd_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) ent_q[wr_q] <= op_i;
  end

endmodule

// ----- rtl/core/pmct_back.sv -----
// Back end: button tracking, timers, click counters, cursor and acknowledges.
// Holds the result register. Depends on pmct_pkg and pmct_out_if.
`timescale 1ns / 1ps

module pmct_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pmct_pkg::cfg_t    cfg_i,
  input  pmct_pkg::op_t     head_i,
  input  pmct_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  pmct_out_if.source        out_o
);

  localparam int NB = pmct_pkg::NUM_BUTTONS;
  localparam int BW = pmct_pkg::BTN_W;

  logic [BW-1:0] held_q, held_d;
  logic [BW-1:0] press_q, press_d;
  logic [BW-1:0] rel_q, rel_d;
  logic [6:0]    hold_q [NB];
  logic [6:0]    hold_d [NB];
  logic [7:0]    clk_q  [NB];
  logic [7:0]    clk_d  [NB];
  logic [11:0]   posx_q, posx_d, posy_q, posy_d;
  logic          out_valid_q;
  pmct_pkg::res_t res_q, res_d;
  logic          pkt;

  assign pop_o = !q_stat_i.empty && (!out_valid_q || out_o.ready);
  assign pkt   = head_i.is_pkt && (head_i.cmd == pmct_pkg::CMD_BYTE);

  always_comb begin
    logic       found;
    logic [6:0] t;
    held_d  = held_q;
    press_d = press_q;
    rel_d   = rel_q;
    hold_d  = hold_q;
    clk_d   = clk_q;
    posx_d  = posx_q;
    posy_d  = posy_q;
    found   = 1'b0;
    t       = '0;
    if (head_i.cmd == pmct_pkg::CMD_BYTE) begin
      if (pkt) begin
        held_d = head_i.buttons;
        for (int i = 0; i < NB; i++) begin
          t = hold_q[i];
          if (head_i.buttons[i] && !held_q[i]) begin
            press_d[i] = 1'b1;
            t          = '0;
          end
          if (!head_i.buttons[i] && held_q[i]) begin
            rel_d[i] = 1'b1;
            if (hold_q[i] < cfg_i.click_lim && clk_q[i] != pmct_pkg::CLICK_MAX) begin
              clk_d[i] = clk_q[i] + 8'd1;
            end
          end
          if (head_i.buttons[i] && t < cfg_i.hold_cap) begin
            t = t + 7'd1;
          end
          hold_d[i] = t;
        end
        posx_d = pmct_pkg::clamp_axis(posx_q, 9'($signed(head_i.dx)), cfg_i.screen_w);
        posy_d = pmct_pkg::clamp_axis(posy_q, -9'($signed(head_i.dy)), cfg_i.screen_h);
      end
    end else begin
      for (int i = 0; i < NB; i++) begin
        if (!found && head_i.mask[i]) begin
          case (head_i.cmd)
            pmct_pkg::CMD_ACK_PRESS: begin
              if (press_q[i]) begin
                press_d[i] = 1'b0;
                found      = 1'b1;
              end
            end
            pmct_pkg::CMD_ACK_RELEASE: begin
              if (rel_q[i]) begin
                rel_d[i] = 1'b0;
                found    = 1'b1;
              end
            end
            pmct_pkg::CMD_ACK_CLICK: begin
              if (clk_q[i] != '0) begin
                clk_d[i] = clk_q[i] - 8'd1;
                found    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end

    res_d.packet_done     = pkt;
    res_d.report_event    = pkt && (head_i.dx != '0 || head_i.dy != '0 ||
                                    head_i.buttons != held_q);
    res_d.button_state    = held_d;
    res_d.move_x          = pkt ? head_i.dx : 8'd0;
    res_d.move_y          = pkt ? head_i.dy : 8'd0;
    res_d.cursor_x        = posx_d;
    res_d.cursor_y        = posy_d;
    res_d.ack_found       = found;
    res_d.press_pending   = press_d;
    res_d.release_pending = rel_d;
    res_d.click_pending   = '0;
    for (int i = 0; i < NB; i++) begin
      res_d.click_pending[i] = (clk_d[i] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      press_q     <= '0;
      rel_q       <= '0;
      posx_q      <= pmct_pkg::POS_X_RST;
      posy_q      <= pmct_pkg::POS_Y_RST;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        hold_q[i] <= '0;
        clk_q[i]  <= '0;
      end
    end else begin
      if (pop_o) begin
        held_q  <= held_d;
        press_q <= press_d;
        rel_q   <= rel_d;
        posx_q  <= posx_d;
        posy_q  <= posy_d;
        hold_q  <= hold_d;
        clk_q   <= clk_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.packet_done     = res_q.packet_done;
  assign out_o.report_event    = res_q.report_event;
  assign out_o.button_state    = res_q.button_state;
  assign out_o.move_x          = res_q.move_x;
  assign out_o.move_y          = res_q.move_y;
  assign out_o.cursor_x        = res_q.cursor_x;
  assign out_o.cursor_y        = res_q.cursor_y;
  assign out_o.ack_found       = res_q.ack_found;
  assign out_o.press_pending   = res_q.press_pending;
  assign out_o.release_pending = res_q.release_pending;
  assign out_o.click_pending   = res_q.click_pending;

`ifndef SYNTHESIS
  a_byte_no_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.cmd == pmct_pkg::CMD_BYTE |=> !res_q.ack_found)
    else $error("ack reported for a mouse byte");

  a_ack_no_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.cmd != pmct_pkg::CMD_BYTE |=> !res_q.packet_done && !res_q.report_event)
    else $error("packet reported for an acknowledge");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> $stable(press_q) && $stable(rel_q) && $stable(posx_q) && $stable(posy_q))
    else $error("state changed without a transaction");
`endif

endmodule

// ----- rtl/core/ps2_mouse_packet_click_tracker_top.sv -----
// Top level of the PS/2 mouse packet click tracker.
// Depends on pmct_pkg, pmct_in_if, pmct_out_if, pmct_front, pmct_queue, pmct_back.
`timescale 1ns / 1ps

// Usage:
//   in_i carries one transaction per command: a raw mouse byte (cmd 0) or an
//   acknowledge of press, release or click events for the buttons in
//   ack_mask. Mouse bytes are framed into 3-byte packets; a packet starts
//   only on a byte with bit 3 set.
//   out_o returns exactly one result per input transaction, in order: packet
//   fields, buttons, clamped cursor and the pending event flags.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write screen width, screen height, click
//   limit and hold cap (index 0 to 3); write only while the block is idle.
//   Path: an accepted transaction is written into the op queue, and its result
//   is registered from the queue head into the result register.
//   Throughput: one transaction per cycle while out_o takes results; the back
//   end updates button, timer and cursor state as it pops each op.
//   A two-entry op queue separates framing from execution; a stall on out_o
//   fills the result register, then the queue, then drops in_i.ready.
//   Reset: framing returns to sync search, cursor goes to (400, 300), all
//   flags, timers and counters clear, config registers take their default values.

module ps2_mouse_packet_click_tracker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pmct_in_if.sink                           in_i,
  pmct_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [pmct_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pmct_pkg::CFG_W-1:0]        cfg_wdata_i
);

  pmct_pkg::cfg_t    cfg_q;
  pmct_pkg::q_stat_t q_stat;
  pmct_pkg::op_t     push_op, head_op;
  logic              push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_w  <= pmct_pkg::SCREEN_W_RST;
      cfg_q.screen_h  <= pmct_pkg::SCREEN_H_RST;
      cfg_q.click_lim <= pmct_pkg::CLICK_LIM_RST;
      cfg_q.hold_cap  <= pmct_pkg::HOLD_CAP_RST;
    end else if (cfg_we_i) begin
      unique case (pmct_pkg::cfg_idx_e'(cfg_idx_i))
        pmct_pkg::CFG_SCREEN_W:  cfg_q.screen_w  <= cfg_wdata_i;
        pmct_pkg::CFG_SCREEN_H:  cfg_q.screen_h  <= cfg_wdata_i;
        pmct_pkg::CFG_CLICK_LIM: cfg_q.click_lim <= cfg_wdata_i[6:0];
        pmct_pkg::CFG_HOLD_CAP:  cfg_q.hold_cap  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  pmct_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .op_o     (push_op)
  );

  pmct_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .head_o (head_op),
    .stat_o (q_stat)
  );

  pmct_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head_op),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
